FILE: hdl/adc_seq_pkg.sv
package adc_seq_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam logic [7:0] ENABLE_TICKS = 8'd1;
    localparam logic [7:0] DISABLE_TICKS = 8'd1;

    localparam logic [4:0] LAST_MSB_IDX = 5'(SAMPLE_BITS - 1);
    localparam logic [4:0] LAST_BIT_IDX = 5'(2 * SAMPLE_BITS - 2);
    localparam logic [4:0] LAST_SEND_IDX = 5'd5;
    localparam logic [4:0] WINDOW_SEND_IDX = 5'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CS_HIGH      = 3'd0,
        REG_CS_SETUP     = 3'd1,
        REG_DATA_SETUP   = 3'd2,
        REG_DATA_HOLD    = 3'd3,
        REG_CLOCK_HIGH   = 3'd4,
        REG_CLOCK_LOW    = 3'd5,
        REG_OUTPUT_VALID = 3'd6,
        REG_BLEED_LIMIT  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic       start_req;
        logic [3:0] channel_code;
        logic       monitor_mode;
        logic       dout_level;
    } in_item_t;

    typedef struct packed {
        logic                   cs_pin;
        logic                   clk_pin;
        logic                   din_pin;
        logic                   busy_res;
        logic                   done_res;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   err_idle_dout;
        logic                   err_null_bit;
        logic                   err_end_dout;
        logic                   err_bleed;
        logic                   err_mismatch;
    } out_item_t;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [7:0] larger(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic chan_bit(input logic [3:0] ch, input logic [4:0] j);
        logic r;
        case (j)
            5'd0: r = ch[3];
            5'd1: r = ch[2];
            5'd2: r = ch[1];
            default: r = ch[0];
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/adc_spi_readout_sequencer.sv
// A result is registered on the clock edge that accepts its input transaction.
// Throughput: one transaction per cycle while the consumer takes results; the frame sequencer advances once per tick.
// Input ready drops only while a registered result waits for the consumer.
// Reset (aresetn low, synchronous): sequencer idle, timing registers at defaults,
// output register empty.
module adc_spi_readout_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  adc_seq_pkg::in_item_t               s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output adc_seq_pkg::out_item_t              m_data,
    input  logic                                cfg_we,
    input  logic [adc_seq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adc_seq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import adc_seq_pkg::*;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_RESET     = 9'b000000010,
        PH_SETUP     = 9'b000000100,
        PH_SEND_HIGH = 9'b000001000,
        PH_SEND_LOW  = 9'b000010000,
        PH_NULL      = 9'b000100000,
        PH_RECV_HIGH = 9'b001000000,
        PH_RECV_LOW  = 9'b010000000,
        PH_END       = 9'b100000000
    } phase_t;

    logic [7:0]  cs_high_reg, cs_setup_reg, data_setup_reg, data_hold_reg;
    logic [7:0]  clock_high_reg, clock_low_reg, output_valid_reg;
    logic [15:0] bleed_limit_reg;

    phase_t                 phase_reg, phase_next, ph_e;
    logic [7:0]             tick_reg, tick_next, tick_e;
    logic [4:0]             bit_reg, bit_next, bit_e;
    logic [SAMPLE_BITS-1:0] msb_reg, msb_next, msb_e;
    logic [SAMPLE_BITS-1:0] lsb_reg, lsb_next, lsb_e;
    logic [3:0]             chan_reg, chan_next, chan_e;
    logic                   mon_reg, mon_next, mon_e;
    logic [15:0]            win_reg, win_next, win_e;
    logic [2:0]             lev_reg, lev_next, lev_e;

    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, out_next;

    logic                   s_fire;
    logic [8:0]             k;
    logic [7:0]             len;
    logic [7:0]             ov_len;
    logic [4:0]             lsb_sh;
    logic                   in_window;
    logic                   done;
    logic                   dout;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign dout    = s_data.dout_level;
    assign ov_len  = at_least_one(output_valid_reg);

    always_comb begin
        ph_e   = phase_reg;
        tick_e = tick_reg;
        bit_e  = bit_reg;
        msb_e  = msb_reg;
        lsb_e  = lsb_reg;
        chan_e = chan_reg;
        mon_e  = mon_reg;
        win_e  = win_reg;
        lev_e  = lev_reg;
        if (phase_reg == PH_IDLE && s_data.start_req) begin
            ph_e   = PH_RESET;
            tick_e = 8'd0;
            bit_e  = 5'd0;
            msb_e  = '0;
            lsb_e  = '0;
            chan_e = s_data.channel_code;
            mon_e  = s_data.monitor_mode;
            win_e  = 16'd0;
            lev_e  = 3'd0;
        end

        k      = {1'b0, tick_e} + 9'd1;
        lsb_sh = bit_e - LAST_MSB_IDX;

        case (ph_e)
            PH_RESET:     len = at_least_one(cs_high_reg);
            PH_SETUP:     len = at_least_one(larger(cs_setup_reg, data_setup_reg));
            PH_SEND_HIGH: len = at_least_one(data_hold_reg);
            PH_SEND_LOW:  len = at_least_one(data_setup_reg);
            PH_NULL:      len = mon_e ? at_least_one(larger(ENABLE_TICKS, clock_low_reg))
                                      : at_least_one(clock_low_reg);
            PH_RECV_HIGH: len = at_least_one(clock_high_reg);
            PH_RECV_LOW:  len = at_least_one(larger(output_valid_reg, clock_low_reg));
            default:      len = at_least_one(DISABLE_TICKS);
        endcase

        phase_next = ph_e;
        tick_next  = tick_e;
        bit_next   = bit_e;
        msb_next   = msb_e;
        lsb_next   = lsb_e;
        chan_next  = chan_e;
        mon_next   = mon_e;
        win_next   = win_e;
        lev_next   = lev_e;
        in_window  = 1'b0;
        done       = 1'b0;
        out_next   = '0;
        out_next.cs_pin = 1'b1;

        case (ph_e)
            PH_IDLE: begin
            end
            PH_RESET: begin
                if (k >= {1'b0, len} && mon_e && !dout) begin
                    lev_next[0] = 1'b1;
                end
            end
            PH_SETUP: begin
                out_next.cs_pin  = 1'b0;
                out_next.din_pin = 1'b1;
            end
            PH_SEND_HIGH: begin
                out_next.cs_pin  = 1'b0;
                out_next.clk_pin = 1'b1;
                out_next.din_pin = (bit_e == 5'd0) ? 1'b1 : chan_bit(chan_e, bit_e - 5'd1);
                if (bit_e == WINDOW_SEND_IDX && tick_e == 8'd0) begin
                    win_next = 16'd0;
                end else if (bit_e >= WINDOW_SEND_IDX) begin
                    in_window = 1'b1;
                end
            end
            PH_SEND_LOW: begin
                out_next.cs_pin  = 1'b0;
                out_next.din_pin = chan_bit(chan_e, bit_e);
                in_window = (bit_e == WINDOW_SEND_IDX);
            end
            PH_NULL: begin
                out_next.cs_pin  = 1'b0;
                out_next.din_pin = chan_e[0];
                in_window = 1'b1;
                if (mon_e && k == {1'b0, at_least_one(ENABLE_TICKS)} && dout) begin
                    lev_next[1] = 1'b1;
                end
            end
            PH_RECV_HIGH: begin
                out_next.cs_pin  = 1'b0;
                out_next.clk_pin = 1'b1;
                out_next.din_pin = chan_e[0];
                in_window = (bit_e <= LAST_MSB_IDX);
            end
            PH_RECV_LOW: begin
                out_next.cs_pin  = 1'b0;
                out_next.din_pin = chan_e[0];
                in_window = (bit_e < LAST_MSB_IDX)
                         || (bit_e == LAST_MSB_IDX && k <= {1'b0, ov_len});
                if (k == {1'b0, ov_len}) begin
                    if (bit_e <= LAST_MSB_IDX) begin
                        msb_next = {msb_e[SAMPLE_BITS-2:0], dout};
                    end
                    if (bit_e >= LAST_MSB_IDX && bit_e <= LAST_BIT_IDX) begin
                        lsb_next = lsb_e | ({{(SAMPLE_BITS-1){1'b0}}, dout} << lsb_sh);
                    end
                end
            end
            default: begin
                out_next.din_pin = chan_e[0];
                if (k >= {1'b0, len}) begin
                    done = 1'b1;
                    if (mon_e && !dout) begin
                        lev_next[2] = 1'b1;
                    end
                end
            end
        endcase

        if (in_window && win_e != 16'hFFFF) begin
            win_next = win_e + 16'd1;
        end

        out_next.busy_res = (ph_e != PH_IDLE);
        out_next.done_res = done;
        if (done) begin
            out_next.sample_value = msb_next;
            if (mon_e) begin
                out_next.err_idle_dout = lev_next[0];
                out_next.err_null_bit  = lev_next[1];
                out_next.err_end_dout  = lev_next[2];
                out_next.err_bleed     = (win_next > bleed_limit_reg);
                out_next.err_mismatch  = (msb_next != lsb_next);
            end
        end

        if (ph_e != PH_IDLE) begin
            if (k < {1'b0, len}) begin
                tick_next = k[7:0];
            end else begin
                tick_next = 8'd0;
                case (ph_e)
                    PH_RESET: phase_next = PH_SETUP;
                    PH_SETUP: begin
                        phase_next = PH_SEND_HIGH;
                        bit_next   = 5'd0;
                    end
                    PH_SEND_HIGH: begin
                        if (bit_e >= LAST_SEND_IDX) begin
                            phase_next = PH_NULL;
                            bit_next   = 5'd0;
                        end else begin
                            phase_next = PH_SEND_LOW;
                        end
                    end
                    PH_SEND_LOW: begin
                        phase_next = PH_SEND_HIGH;
                        bit_next   = bit_e + 5'd1;
                    end
                    PH_NULL: begin
                        phase_next = PH_RECV_HIGH;
                        bit_next   = 5'd0;
                    end
                    PH_RECV_HIGH: phase_next = PH_RECV_LOW;
                    PH_RECV_LOW: begin
                        if (bit_e >= LAST_BIT_IDX || (bit_e >= LAST_MSB_IDX && !mon_e)) begin
                            phase_next = PH_END;
                        end else begin
                            phase_next = PH_RECV_HIGH;
                            bit_next   = bit_e + 5'd1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        bit_next   = 5'd0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= 8'd0;
            bit_reg     <= 5'd0;
            msb_reg     <= '0;
            lsb_reg     <= '0;
            chan_reg    <= 4'd0;
            mon_reg     <= 1'b0;
            win_reg     <= 16'd0;
            lev_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                msb_reg   <= msb_next;
                lsb_reg   <= lsb_next;
                chan_reg  <= chan_next;
                mon_reg   <= mon_next;
                win_reg   <= win_next;
                lev_reg   <= lev_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_high_reg      <= 8'd4;
            cs_setup_reg     <= 8'd1;
            data_setup_reg   <= 8'd1;
            data_hold_reg    <= 8'd1;
            clock_high_reg   <= 8'd1;
            clock_low_reg    <= 8'd1;
            output_valid_reg <= 8'd1;
            bleed_limit_reg  <= 16'd1000;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_CS_HIGH:      cs_high_reg      <= cfg_wdata[7:0];
                REG_CS_SETUP:     cs_setup_reg     <= cfg_wdata[7:0];
                REG_DATA_SETUP:   data_setup_reg   <= cfg_wdata[7:0];
                REG_DATA_HOLD:    data_hold_reg    <= cfg_wdata[7:0];
                REG_CLOCK_HIGH:   clock_high_reg   <= cfg_wdata[7:0];
                REG_CLOCK_LOW:    clock_low_reg    <= cfg_wdata[7:0];
                REG_OUTPUT_VALID: output_valid_reg <= cfg_wdata[7:0];
                REG_BLEED_LIMIT:  bleed_limit_reg  <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // completed frame returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && out_next.done_res) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after frame completion");

    a_idle_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && phase_reg == PH_IDLE && !s_data.start_req) |=> (phase_reg == PH_IDLE))
        else $error("sequencer left idle without a start request");

    a_idle_cs_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.busy_res) |-> m_data_reg.cs_pin)
        else $error("chip select driven low outside a frame");

    a_quiet_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.done_res) |->
        (m_data_reg.sample_value == '0 && !m_data_reg.err_idle_dout
         && !m_data_reg.err_null_bit && !m_data_reg.err_end_dout
         && !m_data_reg.err_bleed && !m_data_reg.err_mismatch))
        else $error("sample or error flags set without done");

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adc_seq_pkg::*;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_RESET,
        SQ_SETUP,
        SQ_SEND_HIGH,
        SQ_SEND_LOW,
        SQ_NULL,
        SQ_RECV_HIGH,
        SQ_RECV_LOW,
        SQ_END
    } seq_phase_t;

    typedef enum logic [1:0] {
        STYLE_CLEAN,
        STYLE_FAULTY,
        STYLE_NOISE
    } frame_style_t;

    typedef struct {
        in_item_t  item;
        out_item_t want;
    } tick_entry_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // shadow of the timing registers, reset values
    logic [15:0] timing_regs [8] = '{16'd4, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1000};
    logic [15:0] next_timing [8];

    seq_phase_t  sq_phase = SQ_IDLE;
    logic [7:0]  sq_ticks = '0;
    logic [4:0]  sq_bit = '0;
    logic [9:0]  sq_msb = '0;
    logic [9:0]  sq_lsb = '0;
    logic [3:0]  sq_chan = '0;
    logic        sq_mon = 1'b0;
    logic [15:0] sq_window = '0;
    logic [2:0]  sq_lvl = '0;

    tick_entry_t pending_ticks [$];
    out_item_t   predicted_pins [$];
    out_item_t   flight_want;
    int          outstanding = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    logic        quiet = 1'b0;

    int fault_count = 0;
    int checked_count = 0;
    int done_count = 0;
    int flagged_count = 0;
    int frames_queued = 0;
    int mon_frames = 0;
    int frame_tick_total = 0;

    adc_spi_readout_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int tick_floor(int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int longer(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic chan_level(logic [4:0] j);
        return (j < 4) ? sq_chan[3 - j] : sq_chan[0];
    endfunction

    function automatic out_item_t frame_tick(in_item_t it);
        out_item_t r;
        int        k;
        int        len;
        int        sample_at;
        logic      win;
        r = '0;
        r.cs_pin = 1'b1;
        win = 1'b0;
        if (sq_phase == SQ_IDLE) begin
            if (!it.start_req)
                return r;
            sq_chan = it.channel_code;
            sq_mon = it.monitor_mode;
            sq_phase = SQ_RESET;
            sq_ticks = '0;
            sq_bit = '0;
            sq_msb = '0;
            sq_lsb = '0;
            sq_window = '0;
            sq_lvl = '0;
        end
        k = int'(sq_ticks) + 1;
        sample_at = tick_floor(timing_regs[REG_OUTPUT_VALID]);
        case (sq_phase)
            SQ_RESET:     len = tick_floor(timing_regs[REG_CS_HIGH]);
            SQ_SETUP:     len = tick_floor(longer(timing_regs[REG_CS_SETUP],
                                                  timing_regs[REG_DATA_SETUP]));
            SQ_SEND_HIGH: len = tick_floor(timing_regs[REG_DATA_HOLD]);
            SQ_SEND_LOW:  len = tick_floor(timing_regs[REG_DATA_SETUP]);
            SQ_NULL:      len = tick_floor(sq_mon ? longer(ENABLE_TICKS, timing_regs[REG_CLOCK_LOW])
                                                  : timing_regs[REG_CLOCK_LOW]);
            SQ_RECV_HIGH: len = tick_floor(timing_regs[REG_CLOCK_HIGH]);
            SQ_RECV_LOW:  len = tick_floor(longer(timing_regs[REG_OUTPUT_VALID],
                                                  timing_regs[REG_CLOCK_LOW]));
            default:      len = tick_floor(DISABLE_TICKS);
        endcase

        case (sq_phase)
            SQ_RESET: begin
                if (k >= len && sq_mon && !it.dout_level)
                    sq_lvl[0] = 1'b1;
            end
            SQ_SETUP: begin
                r.cs_pin = 1'b0;
                r.din_pin = 1'b1;
            end
            SQ_SEND_HIGH: begin
                r.cs_pin = 1'b0;
                r.clk_pin = 1'b1;
                r.din_pin = (sq_bit == 0) ? 1'b1 : chan_level(sq_bit - 5'd1);
                if (sq_bit == WINDOW_SEND_IDX && sq_ticks == 0)
                    sq_window = '0;
                else if (sq_bit >= WINDOW_SEND_IDX)
                    win = 1'b1;
            end
            SQ_SEND_LOW: begin
                r.cs_pin = 1'b0;
                r.din_pin = chan_level(sq_bit);
                if (sq_bit == WINDOW_SEND_IDX)
                    win = 1'b1;
            end
            SQ_NULL: begin
                r.cs_pin = 1'b0;
                r.din_pin = sq_chan[0];
                win = 1'b1;
                if (sq_mon && k == tick_floor(ENABLE_TICKS) && it.dout_level)
                    sq_lvl[1] = 1'b1;
            end
            SQ_RECV_HIGH: begin
                r.cs_pin = 1'b0;
                r.clk_pin = 1'b1;
                r.din_pin = sq_chan[0];
                if (sq_bit <= LAST_MSB_IDX)
                    win = 1'b1;
            end
            SQ_RECV_LOW: begin
                r.cs_pin = 1'b0;
                r.din_pin = sq_chan[0];
                if (sq_bit < LAST_MSB_IDX || (sq_bit == LAST_MSB_IDX && k <= sample_at))
                    win = 1'b1;
                if (k == sample_at) begin
                    if (sq_bit <= LAST_MSB_IDX)
                        sq_msb = {sq_msb[8:0], it.dout_level};
                    if (sq_bit >= LAST_MSB_IDX && sq_bit <= LAST_BIT_IDX)
                        sq_lsb = sq_lsb | (10'(it.dout_level) << (sq_bit - LAST_MSB_IDX));
                end
            end
            default: begin
                r.din_pin = sq_chan[0];
                if (k >= len) begin
                    r.done_res = 1'b1;
                    if (sq_mon && !it.dout_level)
                        sq_lvl[2] = 1'b1;
                end
            end
        endcase

        if (win && sq_window != 16'hFFFF)
            sq_window++;

        r.busy_res = 1'b1;
        if (r.done_res) begin
            r.sample_value = sq_msb;
            if (sq_mon) begin
                r.err_idle_dout = sq_lvl[0];
                r.err_null_bit = sq_lvl[1];
                r.err_end_dout = sq_lvl[2];
                r.err_bleed = (sq_window > timing_regs[REG_BLEED_LIMIT]);
                r.err_mismatch = (sq_msb != sq_lsb);
            end
        end

        if (k < len) begin
            sq_ticks = 8'(k);
        end else begin
            sq_ticks = '0;
            case (sq_phase)
                SQ_RESET: sq_phase = SQ_SETUP;
                SQ_SETUP: begin
                    sq_phase = SQ_SEND_HIGH;
                    sq_bit = '0;
                end
                SQ_SEND_HIGH: begin
                    if (sq_bit >= LAST_SEND_IDX) begin
                        sq_phase = SQ_NULL;
                        sq_bit = '0;
                    end else begin
                        sq_phase = SQ_SEND_LOW;
                    end
                end
                SQ_SEND_LOW: begin
                    sq_phase = SQ_SEND_HIGH;
                    sq_bit++;
                end
                SQ_NULL: begin
                    sq_phase = SQ_RECV_HIGH;
                    sq_bit = '0;
                end
                SQ_RECV_HIGH: sq_phase = SQ_RECV_LOW;
                SQ_RECV_LOW: begin
                    if (sq_bit >= LAST_BIT_IDX || (sq_bit >= LAST_MSB_IDX && !sq_mon)) begin
                        sq_phase = SQ_END;
                    end else begin
                        sq_phase = SQ_RECV_HIGH;
                        sq_bit++;
                    end
                end
                default: begin
                    sq_phase = SQ_IDLE;
                    sq_bit = '0;
                end
            endcase
        end
        return r;
    endfunction

    // converter side: level of data out for the tick about to be queued
    function automatic logic converter_level(frame_style_t style, logic [9:0] value);
        seq_phase_t ph;
        logic       lvl;
        ph = (sq_phase == SQ_IDLE) ? SQ_RESET : sq_phase;
        if (style == STYLE_NOISE)
            return 1'($urandom);
        case (ph)
            SQ_RESET, SQ_END: lvl = 1'b1;
            SQ_NULL:          lvl = 1'b0;
            SQ_RECV_HIGH, SQ_RECV_LOW: begin
                if (sq_bit <= LAST_MSB_IDX)
                    lvl = value[LAST_MSB_IDX - sq_bit];
                else
                    lvl = value[sq_bit - LAST_MSB_IDX] ^ (style == STYLE_FAULTY);
            end
            default: lvl = 1'($urandom);
        endcase
        if (style == STYLE_FAULTY && (ph == SQ_RESET || ph == SQ_END || ph == SQ_NULL))
            lvl = !lvl;
        return lvl;
    endfunction

    function automatic void queue_tick(in_item_t it);
        tick_entry_t e;
        e.item = it;
        e.want = frame_tick(it);
        pending_ticks.push_back(e);
    endfunction

    task automatic queue_idle(input int n);
        in_item_t it;
        for (int i = 0; i < n; i++) begin
            it = in_item_t'($urandom);
            it.start_req = 1'b0;
            queue_tick(it);
        end
    endtask

    task automatic queue_frame(input logic [3:0] ch, input logic mon,
                               input frame_style_t style, input logic [9:0] value);
        in_item_t it;
        it.start_req = 1'b1;
        it.channel_code = ch;
        it.monitor_mode = mon;
        frames_queued++;
        if (mon)
            mon_frames++;
        do begin
            it.dout_level = converter_level(style, value);
            queue_tick(it);
            frame_tick_total++;
            // start requests while busy must be ignored
            it.start_req = ($urandom_range(0, 3) == 0);
            it.channel_code = 4'($urandom);
            it.monitor_mode = 1'($urandom);
        end while (sq_phase != SQ_IDLE);
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic program_timing();
        drain();
        repeat (3) @(posedge aclk);
        for (int i = REG_CS_HIGH; i <= REG_BLEED_LIMIT; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            if (i == REG_BLEED_LIMIT) begin
                cfg_wdata <= next_timing[i];
                timing_regs[i] = next_timing[i];
            end else begin
                // upper byte must be dropped
                cfg_wdata <= {8'($urandom), next_timing[i][7:0]};
                timing_regs[i] = {8'h00, next_timing[i][7:0]};
            end
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic uniform_timing(input logic [7:0] t, input logic [15:0] bleed);
        for (int i = REG_CS_HIGH; i < REG_BLEED_LIMIT; i++)
            next_timing[i] = {8'h00, t};
        next_timing[REG_BLEED_LIMIT] = bleed;
        program_timing();
    endtask

    always @(posedge aclk) begin : tick_driver
        tick_entry_t e;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predicted_pins.push_back(flight_want);
            if (!s_valid || s_ready) begin
                if (quiet)
                    src_gap = 0;
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    e = pending_ticks.pop_front();
                    s_valid <= 1'b1;
                    s_data <= e.item;
                    flight_want = e.want;
                    outstanding++;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : pin_monitor
        out_item_t want;
        string     bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_pins.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result at %0t: got %p", $time, m_data);
                end else begin
                    want = predicted_pins.pop_front();
                    outstanding--;
                    checked_count++;
                    bad = "";
                    if (m_data.cs_pin !== want.cs_pin)               bad = {bad, " cs_pin"};
                    if (m_data.clk_pin !== want.clk_pin)             bad = {bad, " clk_pin"};
                    if (m_data.din_pin !== want.din_pin)             bad = {bad, " din_pin"};
                    if (m_data.busy_res !== want.busy_res)           bad = {bad, " busy_res"};
                    if (m_data.done_res !== want.done_res)           bad = {bad, " done_res"};
                    if (m_data.sample_value !== want.sample_value)   bad = {bad, " sample_value"};
                    if (m_data.err_idle_dout !== want.err_idle_dout) bad = {bad, " err_idle_dout"};
                    if (m_data.err_null_bit !== want.err_null_bit)   bad = {bad, " err_null_bit"};
                    if (m_data.err_end_dout !== want.err_end_dout)   bad = {bad, " err_end_dout"};
                    if (m_data.err_bleed !== want.err_bleed)         bad = {bad, " err_bleed"};
                    if (m_data.err_mismatch !== want.err_mismatch)   bad = {bad, " err_mismatch"};
                    if (bad != "") begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch at %0t on%s: expected %p got %p",
                                     $time, bad, want, m_data);
                    end
                    if (want.done_res) begin
                        done_count++;
                        if (want.err_idle_dout || want.err_null_bit || want.err_end_dout ||
                            want.err_bleed || want.err_mismatch)
                            flagged_count++;
                    end
                end
            end
            if (quiet)
                sink_gap = 0;
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
        end
    end

    initial begin
        int           random_base;
        int           phase_base;
        int           pick;
        frame_style_t style;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset timing values
        queue_idle(2);
        queue_frame(4'h0, 1'b1, STYLE_CLEAN, 10'h000);
        queue_frame(4'hF, 1'b1, STYLE_CLEAN, 10'h3FF);
        queue_frame(4'h5, 1'b1, STYLE_FAULTY, 10'h2AA);
        queue_frame(4'hA, 1'b0, STYLE_NOISE, 10'($urandom));
        queue_frame(4'h3, 1'b0, STYLE_CLEAN, 10'h155);
        queue_idle(1);

        // all counts zero: every phase one tick, bleed limit zero
        uniform_timing(8'd0, 16'd0);
        queue_frame(4'h9, 1'b1, STYLE_CLEAN, 10'h201);
        queue_frame(4'h6, 1'b1, STYLE_FAULTY, 10'h0FF);
        queue_frame(4'hC, 1'b0, STYLE_CLEAN, 10'h3C3);

        // skewed: sample on first low tick, data setup shorter than chip select setup
        next_timing[REG_CS_HIGH] = 16'd0;
        next_timing[REG_CS_SETUP] = 16'd3;
        next_timing[REG_DATA_SETUP] = 16'd0;
        next_timing[REG_DATA_HOLD] = 16'd2;
        next_timing[REG_CLOCK_HIGH] = 16'd0;
        next_timing[REG_CLOCK_LOW] = 16'd3;
        next_timing[REG_OUTPUT_VALID] = 16'd0;
        next_timing[REG_BLEED_LIMIT] = 16'd30;
        program_timing();
        queue_frame(4'h1, 1'b1, STYLE_CLEAN, 10'h133);
        queue_frame(4'h7, 1'b1, STYLE_NOISE, 10'($urandom));

        random_base = frame_tick_total;
        while (frame_tick_total - random_base < 220) begin
            for (int i = REG_CS_HIGH; i < REG_BLEED_LIMIT; i++)
                next_timing[i] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 4));
            pick = $urandom_range(0, 3);
            if (pick == 0)
                next_timing[REG_BLEED_LIMIT] = 16'($urandom);
            else if (pick == 1)
                next_timing[REG_BLEED_LIMIT] = 16'd1000;
            else
                next_timing[REG_BLEED_LIMIT] = 16'($urandom_range(0, 80));
            program_timing();
            if (frame_tick_total - random_base >= 110)
                quiet = 1'b1;
            phase_base = frame_tick_total;
            while (frame_tick_total - phase_base < 110) begin
                queue_idle($urandom_range(0, 3));
                pick = $urandom_range(0, 9);
                style = (pick < 7) ? STYLE_CLEAN : (pick < 9) ? STYLE_NOISE : STYLE_FAULTY;
                queue_frame(4'($urandom), ($urandom_range(0, 3) != 0), style, 10'($urandom));
            end
        end
        queue_idle(2);

        drain();
        repeat (4) @(posedge aclk);
        $display("%0d frames (%0d with monitoring), %0d ticks checked", frames_queued,
                 mon_frames, checked_count);
        $display("%0d conversions completed, %0d with error flags raised", done_count,
                 flagged_count);
        if (fault_count == 0) begin
            $display("PASS adc_spi_readout_sequencer");
        end else begin
            $display("%0d failures", fault_count);
            $display("FAIL adc_spi_readout_sequencer");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout: %0d ticks still outstanding", outstanding + pending_ticks.size());
        $display("FAIL adc_spi_readout_sequencer");
        $finish;
    end

endmodule
